/* rtl/core/smm_pkg.sv */
// package: shared types, codes and defaults for the segmented memory manager
package smm_pkg;
	localparam int MAX_SEGMENTS_DEF  = 256;
	localparam int SEGMENT_WORDS_DEF = 1024;

	typedef enum logic [2:0] {
		FN_MAP    = 3'd0,
		FN_UNMAP  = 3'd1,
		FN_LOAD   = 3'd2,
		FN_STORE  = 3'd3,
		FN_LDPROG = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADSEG = 2'd1,
		ST_OFFSET = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ZERO,
		S_CRD,
		S_CWR,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;     // capture request
		logic eval;      // table lookup done, decide
		logic zero_step; // write one zero word
		logic copy_rd;   // read source word
		logic copy_wr;   // write copied word
		logic finish;    // commit result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_zero;
		logic need_copy;
		logic walk_done;
	} stat_t;
endpackage

/* rtl/core/smm_ram.sv */
// generic single port ram with registered read
module smm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/core/smm_ctrl.sv */
// controller state machine
module smm_ctrl import smm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				priority if (st.need_zero) state_d = S_ZERO;
				else if (st.need_copy)     state_d = S_CRD;
				else                       state_d = S_OUT;
			end
			S_ZERO: begin
				cmd.zero_step = 1'b1;
				if (st.walk_done) state_d = S_OUT;
			end
			S_CRD: begin
				cmd.copy_rd = 1'b1;
				state_d     = S_CWR;
			end
			S_CWR: begin
				cmd.copy_wr = 1'b1;
				state_d     = st.walk_done ? S_OUT : S_CRD;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/core/smm_dp.sv */
// datapath: segment tables, free stack and word memory
module smm_dp import smm_pkg::*; #(
	parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
	parameter int SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [2:0]  func,
	input  logic [7:0]  segment_id,
	input  logic [9:0]  word_offset,
	input  logic [10:0] map_length,
	input  logic [31:0] write_word,
	output logic [31:0] result_value,
	output logic [1:0]  status
);
	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int OW = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = $clog2(SEGMENT_WORDS + 1);
	localparam int AW = IW + OW;

	// request capture
	logic [2:0]  func_q;
	logic [7:0]  id_q;
	logic [9:0]  off_q;
	logic [10:0] len_q;
	logic [31:0] word_q;

	// mapped flags in flops, cleared on reset
	logic          mapped_q [MAX_SEGMENTS];
	logic [CW-1:0] depth_q, issued_q;

	logic [31:0]   res_q;
	status_t       stat_q;
	logic [IW-1:0] nid_q;
	logic [LW-1:0] cnt_q, wlen_q;
	logic [IW-1:0] src_q;

	logic          id_in_range, id_ok;
	logic [IW-1:0] idx;
	assign idx         = IW'(id_q);
	assign id_in_range = (32'(id_q) < 32'(MAX_SEGMENTS));
	assign id_ok       = id_in_range && mapped_q[idx];

	// free stack ram
	logic          fs_we;
	logic [IW-1:0] fs_addr, fs_rdata;

	always_comb begin
		fs_we   = 1'b0;
		fs_addr = depth_q[IW-1:0] - IW'(1);
		if (cmd.eval && func_q == FN_UNMAP && id_ok && idx != '0
				&& depth_q < CW'(MAX_SEGMENTS)) begin
			fs_we   = 1'b1;
			fs_addr = depth_q[IW-1:0];
		end
	end

	// free stack top read occurs in S_EVAL; address set from latch cycle
	smm_ram #(.WIDTH(IW), .DEPTH(MAX_SEGMENTS)) u_fs (
		.clk(clk), .we(fs_we), .addr(fs_addr),
		.wdata(idx), .rdata(fs_rdata)
	);

	// map decision
	logic          len_fit, id_avail, map_go, prog_go, off_ok;
	logic [IW-1:0] new_id;
	assign len_fit  = (32'(len_q) <= 32'(SEGMENT_WORDS));
	assign id_avail = (depth_q != '0) || (issued_q < CW'(MAX_SEGMENTS));
	assign new_id   = (depth_q != '0) ? fs_rdata : issued_q[IW-1:0];
	assign map_go   = (func_q == FN_MAP) && len_fit && id_avail;

	// segment length ram: read at the request's id in the latch cycle, so the
	// entry is ready in S_EVAL; entries are only used while mapped
	logic          len_we;
	logic [IW-1:0] len_addr;
	logic [LW-1:0] len_wdata, len_rdata;

	assign prog_go = (func_q == FN_LDPROG) && id_ok && mapped_q[0] && idx != '0;
	assign off_ok  = (32'(off_q) < 32'(len_rdata));

	always_comb begin
		len_we    = 1'b0;
		len_addr  = IW'(segment_id);
		len_wdata = LW'(len_q);
		if (cmd.eval && map_go) begin
			len_we   = 1'b1;
			len_addr = new_id;
		end
		if (cmd.eval && prog_go) begin
			len_we    = 1'b1;
			len_addr  = '0;
			len_wdata = len_rdata;
		end
	end

	smm_ram #(.WIDTH(LW), .DEPTH(MAX_SEGMENTS)) u_len (
		.clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wdata), .rdata(len_rdata)
	);

	// word memory
	logic          wm_we;
	logic [AW-1:0] wm_addr;
	logic [31:0]   wm_wdata, wm_rdata;

	always_comb begin
		wm_we    = 1'b0;
		wm_addr  = {idx, OW'(off_q)};
		wm_wdata = word_q;
		if (cmd.eval && func_q == FN_STORE && id_ok && off_ok) begin
			wm_we = 1'b1;
		end
		if (cmd.zero_step) begin
			wm_we    = 1'b1;
			wm_addr  = {nid_q, cnt_q[OW-1:0]};
			wm_wdata = '0;
		end
		if (cmd.copy_rd) begin
			wm_addr = {src_q, cnt_q[OW-1:0]};
		end
		if (cmd.copy_wr) begin
			wm_we    = 1'b1;
			wm_addr  = {{IW{1'b0}}, cnt_q[OW-1:0]};
			wm_wdata = wm_rdata;
		end
	end

	smm_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_wm (
		.clk(clk), .we(wm_we), .addr(wm_addr), .wdata(wm_wdata), .rdata(wm_rdata)
	);

	// load data appears in the cycle after eval; held flag picks it at output
	logic load_hit_q;

	assign st.need_zero = map_go && (len_q != '0);
	assign st.need_copy = prog_go && (len_rdata != '0);
	assign st.walk_done = (cnt_q + LW'(1) >= wlen_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			id_q   <= segment_id;
			off_q  <= word_offset;
			len_q  <= map_length;
			word_q <= write_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				mapped_q[i] <= 1'b0;
			end
			depth_q    <= '0;
			issued_q   <= '0;
			load_hit_q <= 1'b0;
			stat_q     <= ST_OK;
			res_q      <= '0;
			nid_q      <= '0;
			cnt_q      <= '0;
			wlen_q     <= '0;
			src_q      <= '0;
		end else begin
			if (cmd.eval) begin
				res_q      <= '0;
				stat_q     <= ST_OK;
				load_hit_q <= 1'b0;
				cnt_q      <= '0;
				unique case (func_q)
					FN_MAP: begin
						if (map_go) begin
							if (depth_q != '0) begin
								depth_q <= depth_q - CW'(1);
							end else begin
								issued_q <= issued_q + CW'(1);
							end
							nid_q            <= new_id;
							mapped_q[new_id] <= 1'b1;
							wlen_q           <= LW'(len_q);
							res_q            <= 32'(new_id);
						end else begin
							stat_q <= ST_FULL;
						end
					end
					FN_UNMAP: begin
						if (!id_ok || idx == '0) begin
							stat_q <= ST_BADSEG;
						end else begin
							mapped_q[idx] <= 1'b0;
							if (depth_q < CW'(MAX_SEGMENTS)) depth_q <= depth_q + CW'(1);
						end
					end
					FN_LOAD, FN_STORE: begin
						if (!id_ok) stat_q <= ST_BADSEG;
						else if (!off_ok) stat_q <= ST_OFFSET;
						else load_hit_q <= (func_q == FN_LOAD);
					end
					FN_LDPROG: begin
						if (!id_ok || !mapped_q[0]) begin
							stat_q <= ST_BADSEG;
						end else if (prog_go) begin
							wlen_q <= len_rdata;
							src_q  <= idx;
						end
					end
					default: ;
				endcase
			end
			if (cmd.zero_step || cmd.copy_wr) begin
				cnt_q <= cnt_q + LW'(1);
			end
		end
	end

	assign result_value = load_hit_q ? wm_rdata : res_q;
	assign status       = stat_q;
endmodule

/* rtl/core/segmented_memory_manager_unit.sv */
// top level of the segmented memory manager
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  request  | in_valid / in_ready   | func segment_id word_offset map_length
//           |                       | write_word
//  result   | out_valid / out_ready | result_value status
//
// a request passes through capture, table lookup and result, plus output wait
// map adds a walk that zeroes each word; load program adds a walk that reads
// then writes each copied word, both set by the single port of the word memory
// reset clears the mapped flags and the stack counters at once; a length
// entry is written by map before it can be read
// one request in flight; in_ready is low until its result is taken
module segmented_memory_manager_unit import smm_pkg::*; #(
	parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
	parameter int SEGMENT_WORDS = SEGMENT_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  segment_id,
	input  logic [9:0]  word_offset,
	input  logic [10:0] map_length,
	input  logic [31:0] write_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [1:0]  status
);
	cmd_t  cmd;
	stat_t st;

	// sequencer
	smm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
	);

	// tables, free stack and word storage
	smm_dp #(.MAX_SEGMENTS(MAX_SEGMENTS), .SEGMENT_WORDS(SEGMENT_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.func(func), .segment_id(segment_id), .word_offset(word_offset),
		.map_length(map_length), .write_word(write_word),
		.result_value(result_value), .status(status)
	);
endmodule

/* rtl/core/smm_checker.sv */
// port level checks for the segmented memory manager
module smm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_value,
	input logic [1:0]  status
);
	// one request in flight: no accept while result pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	// accept gives no result in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	// errors carry zero value
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 2'd0) |-> result_value == 32'd0)
		else $error("nonzero value on error");
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_value)))
		else $error("result changed under stall");
endmodule

bind segmented_memory_manager_unit smm_checker u_chk (.*);

/* tb/segmented_memory_manager_unit_tb.sv */
// testbench for the segmented memory manager: random and directed requests checked against a model
module segmented_memory_manager_unit_tb;
	import smm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEG = 256;
	localparam int NWORDS = 1024;

	typedef struct {
		logic [31:0] value;
		status_t     st;
	} seg_result_t;

	// segment memory model and its checker
	class seg_scoreboard;
		logic [31:0] words [int];
		logic [10:0] seg_len [NSEG];
		bit          seg_mapped [NSEG];
		logic [7:0]  free_ids [NSEG];
		int          free_depth;
		int          issued;
		seg_result_t pending [$];
		int          errors;
		int          checked;

		function new();
			for (int i = 0; i < NSEG; i++) begin
				seg_len[i] = '0;
				seg_mapped[i] = 0;
			end
			free_depth = 0;
			issued = 0;
			errors = 0;
			checked = 0;
		endfunction

		function bit live(int id);
			return seg_mapped[id];
		endfunction

		// apply one accepted request to the model and queue its result
		function void note_request(logic [2:0] f, logic [7:0] id, logic [9:0] off,
				logic [10:0] len, logic [31:0] wr);
			seg_result_t r;
			int nid;
			r.value = '0;
			r.st = ST_OK;
			case (f)
				FN_MAP: begin
					nid = -1;
					if (len > NWORDS) r.st = ST_FULL;
					else if (free_depth > 0) begin
						free_depth--;
						nid = free_ids[free_depth];
					end else if (issued < NSEG) begin
						nid = issued;
						issued++;
					end else r.st = ST_FULL;
					if (nid >= 0) begin
						for (int i = 0; i < len; i++) words[nid * NWORDS + i] = '0;
						seg_len[nid] = len;
						seg_mapped[nid] = 1;
						r.value = 32'(nid);
					end
				end
				FN_UNMAP: begin
					if (!live(id) || id == 0) r.st = ST_BADSEG;
					else begin
						seg_mapped[id] = 0;
						seg_len[id] = '0;
						if (free_depth < NSEG) begin
							free_ids[free_depth] = id;
							free_depth++;
						end
					end
				end
				FN_LOAD, FN_STORE: begin
					if (!live(id)) r.st = ST_BADSEG;
					else if (off >= seg_len[id]) r.st = ST_OFFSET;
					else if (f == FN_LOAD) r.value = words[id * NWORDS + off];
					else words[id * NWORDS + off] = wr;
				end
				FN_LDPROG: begin
					if (!live(id) || !seg_mapped[0]) r.st = ST_BADSEG;
					else if (id != 0) begin
						for (int i = 0; i < seg_len[id]; i++)
							words[i] = words[id * NWORDS + i];
						seg_len[0] = seg_len[id];
					end
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] value, logic [1:0] st);
			seg_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result value=%h status=%0d", value, st);
				return;
			end
			e = pending.pop_front();
			if (value !== e.value || st !== e.st) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d: value exp %h got %h, status exp %0d got %0d",
						checked, e.value, value, e.st, st);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  func = '0;
	logic [7:0]  segment_id = '0;
	logic [9:0]  word_offset = '0;
	logic [10:0] map_length = '0;
	logic [31:0] write_word = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] result_value;
	logic [1:0]  status;

	seg_scoreboard sb = new();
	bit quiet_phase = 0;   // no idling near the end
	int hold_cycles = 0;   // long receiver hold-off, set by the stimulus sequence
	int sent = 0;

	segmented_memory_manager_unit i_dut (.*);

	always #5 clk = ~clk;

	// request driver: presents one request and waits for it to be taken
	task automatic send_request(logic [2:0] f, logic [7:0] id, logic [9:0] off,
			logic [10:0] len, logic [31:0] wr);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		func <= f;
		segment_id <= id;
		word_offset <= off;
		map_length <= len;
		write_word <= wr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge; model it now
		sb.note_request(f, id, off, len, wr);
		sent++;
		@(negedge clk);
	endtask

	// pick a segment id that is usually live
	function automatic logic [7:0] pick_id();
		int tries;
		logic [7:0] id;
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		for (tries = 0; tries < 16; tries++) begin
			id = 8'($urandom_range(0, sb.issued > 0 ? sb.issued - 1 : 0));
			if (sb.live(id)) return id;
		end
		return id;
	endfunction

	task automatic random_request(bit small_only);
		logic [7:0] id;
		logic [9:0] off;
		logic [10:0] len;
		int k;
		k = $urandom_range(0, 99);
		id = pick_id();
		off = (sb.seg_len[id] > 0 && $urandom_range(0, 7) != 0) ?
			10'($urandom_range(0, sb.seg_len[id] - 1)) : 10'($urandom_range(0, 1023));
		if ($urandom_range(0, 40) == 0 && !small_only) len = 11'($urandom_range(1000, 1024));
		else if ($urandom_range(0, 30) == 0) len = 11'($urandom_range(1025, 2047));
		else len = 11'($urandom_range(0, 12));
		if (k < 18) send_request(FN_MAP, id, off, len, $urandom());
		else if (k < 30) send_request(FN_UNMAP, id, off, len, $urandom());
		else if (k < 58) send_request(FN_LOAD, id, off, len, $urandom());
		else if (k < 88) send_request(FN_STORE, id, off, len, $urandom());
		else if (k < 96) send_request(FN_LDPROG, id, off, len, $urandom());
		else send_request(3'($urandom_range(5, 7)), 8'($urandom()), 10'($urandom()),
			11'($urandom()), $urandom());
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 9);
				out_ready <= 0;
				repeat (gap - 1) @(negedge clk);
			end else out_ready <= 1;
		end
	end

	// sample results at the rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_result(result_value, status);

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: error cases on an empty memory, then the boundaries
		send_request(FN_LOAD, 8'd0, 10'd0, 11'd0, '0);
		send_request(FN_LDPROG, 8'd0, 10'd0, 11'd0, '0);
		send_request(FN_UNMAP, 8'd5, 10'd0, 11'd0, '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd1025, '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd1024, '0);
		send_request(FN_STORE, 8'd0, 10'd1023, 11'd0, 32'hFFFF_FFFF);
		send_request(FN_LOAD, 8'd0, 10'd1023, 11'd0, '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd0, '0);
		send_request(FN_LOAD, 8'd1, 10'd0, 11'd0, '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd4, '0);
		send_request(FN_STORE, 8'd2, 10'd3, 11'd0, 32'hA5A5_5A5A);
		send_request(FN_STORE, 8'd2, 10'd4, 11'd0, 32'h1);
		send_request(FN_LDPROG, 8'd2, 10'd0, 11'd0, '0);
		send_request(FN_LOAD, 8'd0, 10'd3, 11'd0, '0);
		send_request(FN_LOAD, 8'd0, 10'd4, 11'd0, '0);
		send_request(FN_LDPROG, 8'd0, 10'd0, 11'd0, '0);
		send_request(FN_UNMAP, 8'd0, 10'd0, 11'd0, '0);
		send_request(FN_UNMAP, 8'd2, 10'd0, 11'd0, '0);
		send_request(FN_UNMAP, 8'd2, 10'd0, 11'd0, '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd2, '0);
		send_request(FN_LOAD, 8'd255, 10'd0, 11'd0, '0);
		send_request(3'd7, 8'hFF, 10'h3FF, 11'h7FF, 32'hFFFF_FFFF);
		// exhaust the id space
		while (sb.issued < NSEG)
			send_request(FN_MAP, 8'd0, 10'd0, 11'($urandom_range(0, 3)), '0);
		send_request(FN_MAP, 8'd0, 10'd0, 11'd1, '0);
		send_request(FN_LOAD, 8'd255, 10'd0, 11'd0, '0);
		// sender pauses until everything is back
		drain();
		// long receiver hold-off while the sender keeps offering
		hold_cycles = 200;
		repeat (10) random_request(1);
		for (int i = 0; i < 610; i++) begin
			if (i == 540) quiet_phase = 1;
			random_request(0);
		end
		drain();
		$display("covered %0d requests: map/unmap churn, loads, stores, program loads, errors",
			sent);
		$display("id space exhausted once, long output stall and idle drain exercised");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS segmented_memory_manager_unit");
		else begin
			$display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
			$display("FAIL segmented_memory_manager_unit");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("FAIL segmented_memory_manager_unit");
		$finish;
	end
endmodule
